FILE: hdl/running_mean_window_top_defines.svh
// Assertion macros for the running mean window block.
// Used by running_mean_window_top; expects clk_i and rst_ni in scope.
`ifndef RUNNING_MEAN_WINDOW_TOP_DEFINES_SVH
`define RUNNING_MEAN_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rmw_pkg.sv
// Shared constants and types for the running mean window block.
// No dependencies; imported by every module of the block.
package rmw_pkg;

  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned SAMPLE_BITS = 32;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned AVG_W    = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W    = SAMPLE_BITS + SLOT_W;
  localparam int unsigned STEP_W   = $clog2(SUM_W);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0]    WINDOW_RESET = LEN_W'(MAX_WINDOW);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK  = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // One division request: the exact window sum and the sample count it covers.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] window_len;
  } front_status_t;

endpackage

FILE: hdl/rmw_queue.sv
// Short request queue between the front end and the divider back end.
// Depends on rmw_pkg for the request type and depth.
module rmw_queue import rmw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      push_job_i,
  input  logic      pop_i,
  output job_t      pop_job_o,
  output q_status_t status_o
);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign pop_job_o       = entry_q[rd_ptr_q];
  assign status_o.full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty  = (cnt_q == '0);

endmodule

FILE: hdl/rmw_front.sv
// Front end: takes samples, keeps the sample ring, fill count and running sum,
// and hands each updated sum to the queue. Depends on rmw_pkg.
module rmw_front import rmw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  q_status_t           q_status_i,
  output logic                push_o,
  output job_t                push_job_o,
  output front_status_t       status_o
);

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_e;

  front_state_e        state_q;
  logic [LEN_W-1:0]    len_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   wr_slot_q;
  logic [LEN_W-1:0]    fill_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [SAMPLE_W-1:0] ring [MAX_WINDOW];

  logic                accept;
  logic [LEN_W-1:0]    len_cfg;
  logic [SLOT_W-1:0]   rd_slot;
  logic [SAMPLE_W-1:0] old_val;
  logic [SUM_W-1:0]    sum_d;
  logic [LEN_W-1:0]    fill_d;
  logic [LEN_W-1:0]    slot_inc;
  logic [SLOT_W-1:0]   slot_d;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == F_UPDATE) && !q_status_i.full;

  always_comb begin
    if (cfg_data_i == '0) begin
      len_cfg = LEN_W'(1);
    end else if (cfg_data_i > LEN_W'(MAX_WINDOW)) begin
      len_cfg = LEN_W'(MAX_WINDOW);
    end else begin
      len_cfg = cfg_data_i;
    end

    rd_slot = (LEN_W'(slot_q) >= len_q) ? '0 : slot_q;

    // Slots at or above the fill count have not been written since the last
    // clear, so they count as zero and the value read from the ring is ignored.
    old_val = (fill_q < len_q) ? '0 : rd_data_q;
    sum_d   = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
    fill_d  = (fill_q < len_q) ? fill_q + 1'b1 : fill_q;

    slot_inc = LEN_W'(wr_slot_q) + 1'b1;
    slot_d   = (slot_inc >= len_q) ? '0 : slot_inc[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      len_q     <= WINDOW_RESET;
      slot_q    <= '0;
      wr_slot_q <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      sample_q  <= '0;
    end else if (cfg_we_i) begin
      len_q  <= len_cfg;
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            sample_q  <= sample_i & SAMPLE_MASK;
            wr_slot_q <= rd_slot;
            state_q   <= F_UPDATE;
          end
        end
        F_UPDATE: begin
          if (!q_status_i.full) begin
            sum_q   <= sum_d;
            fill_q  <= fill_d;
            slot_q  <= slot_d;
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      ring[wr_slot_q] <= sample_q;
    end
    if (accept) begin
      rd_data_q <= ring[rd_slot];
    end
  end

  assign push_job_o.sum   = sum_d;
  assign push_job_o.count = fill_d;

  assign status_o.busy       = (state_q != F_IDLE);
  assign status_o.window_len = len_q;

endmodule

FILE: hdl/rmw_back.sv
// Back end: restoring divider that forms (sum + count/2) / count one quotient
// bit per cycle, followed by the result register. Depends on rmw_pkg.
module rmw_back import rmw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_status_t          q_status_i,
  input  job_t               pop_job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [AVG_W-1:0]   average_o,
  output logic [LEN_W-1:0]   samples_held_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

  back_state_e       state_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [LEN_W-1:0]  rem_q;
  logic [LEN_W-1:0]  div_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic [AVG_W-1:0]  avg_q;
  logic [LEN_W-1:0]  held_q;

  logic [LEN_W:0]    rem_shift;
  logic [LEN_W:0]    rem_diff;
  logic              q_bit;
  logic [LEN_W-1:0]  rem_d;
  logic              out_free;

  assign pop_o    = (state_q == B_IDLE) && !q_status_i.empty;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rem_shift = {rem_q, dvd_q[SUM_W-1]};
    rem_diff  = rem_shift - {1'b0, div_q};
    q_bit     = (rem_shift >= {1'b0, div_q});
    // The remainder stays below the divisor, so it fits back in LEN_W bits.
    rem_d     = q_bit ? rem_diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      held_q      <= '0;
    end else begin
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            dvd_q   <= pop_job_i.sum + SUM_W'(pop_job_i.count >> 1);
            div_q   <= pop_job_i.count;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          // Quotient bits shift in at the bottom as dividend bits leave the top.
          dvd_q  <= {dvd_q[SUM_W-2:0], q_bit};
          rem_q  <= rem_d;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SUM_W - 1)) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            avg_q   <= dvd_q[AVG_W-1:0];
            held_q  <= div_q;
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_o      = avg_q;
  assign samples_held_o = held_q;

endmodule

FILE: hdl/running_mean_window_top.sv
// Running mean over a window of recent samples.
// One request channel in (sample), one request channel out (average and count).
// Channels use valid/stall: a request moves at a clock edge where valid is high
// and stall is low. The window length register is written over a valid/ready
// port that is always ready; a write clears the sample history and count, and
// must only happen while no request is in flight.
// Each sample produces exactly one result: the rounded mean of the last
// window_length samples, or of all samples since the last clear if fewer.
// From input accept to result valid, a request passes the front end (ring
// read, sum update), moves through the queue into the divider, runs in the
// bit-serial divider and then enters the output register.
// Sustained rate is set by the divider, which produces one quotient bit
// per cycle.
// A two-entry queue lets the front end take new samples while the divider runs.
// When the receiver stalls, the result holds in the output register and the
// divider and then the queue back up before the input stalls.
// Reset sets the window length to its maximum and clears the history; the
// sample ring itself is not swept, since the fill count masks stale entries.
// Depends on rmw_pkg, rmw_front, rmw_queue, rmw_back and the defines header.
`include "running_mean_window_top_defines.svh"

module running_mean_window_top import rmw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LEN_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [AVG_W-1:0]    average_o,
  output logic [LEN_W-1:0]    samples_held_o
);

  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          pop_job;
  q_status_t     q_status;
  front_status_t front_status;
  logic          cfg_we;
  logic          in_accept;
  logic          out_settled;
  logic          held_in_range;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  rmw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_job_o (push_job),
    .status_o   (front_status)
  );

  rmw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .status_o   (q_status)
  );

  rmw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .pop_job_i      (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .average_o      (average_o),
    .samples_held_o (samples_held_o)
  );

  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_settled   = out_valid_o && !front_status.busy && q_status.empty;
  assign held_in_range = (samples_held_o != '0) &&
                         (samples_held_o <= front_status.window_len);

  `RMW_ASSERT_IMP(a_push_not_full, push, !q_status.full, "push into a full queue")
  `RMW_ASSERT_IMP(a_pop_not_empty, pop, !q_status.empty, "pop from an empty queue")
  `RMW_ASSERT_NXT(a_accept_busy, in_accept, front_status.busy, "front idle after accept")
  `RMW_ASSERT_IMP(a_held_range, out_settled, held_in_range, "sample count out of range")

endmodule
